// ----- sv/wsialu_pkg.sv -----
// ----------------------------------------------------------------------------
// wsialu_pkg
// Types and constants for the 128-bit signed integer ALU.
// ----------------------------------------------------------------------------
package wsialu_pkg;

  localparam int unsigned WORD_W  = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned SHAMT_W = 7;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned CNT_W   = 7;

  localparam logic [MODE_W-1:0] MODE_ADD = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 4'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 4'd3;
  localparam logic [MODE_W-1:0] MODE_AND = 4'd4;
  localparam logic [MODE_W-1:0] MODE_OR  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_XOR = 4'd6;
  localparam logic [MODE_W-1:0] MODE_NOT = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SHL = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SHR = 4'd9;
  localparam logic [MODE_W-1:0] MODE_ROL = 4'd10;
  localparam logic [MODE_W-1:0] MODE_ROR = 4'd11;
  localparam logic [MODE_W-1:0] MODE_CMP = 4'd12;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [HALF_W-1:0]  a_low;
    logic [HALF_W-1:0]  a_high;
    logic [HALF_W-1:0]  b_low;
    logic [HALF_W-1:0]  b_high;
    logic [SHAMT_W-1:0] shift_amount;
  } in_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_low;
    logic [HALF_W-1:0] result_high;
    logic              is_less;
    logic              is_equal;
    logic              is_greater;
  } out_t;

endpackage

// ----- sv/wide_signed_integer_alu.sv -----
// ----------------------------------------------------------------------------
// wide_signed_integer_alu
// 128-bit two's complement ALU built around one shared 129-bit adder.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  input     in_data                   start, taken when busy is low
//  result    out_data                  out_valid, one-cycle strobe
//
// Add, sub, logic, shifts, rotates, compare: one ST_EXEC state, then the strobe.
// Multiply: 128 shift-add steps on the shared adder, then the strobe.
// Divide: negate A and B where negative, 128 restoring steps, sign fix; when B
// is zero it takes ST_EXEC and returns zero. busy stays high until the strobe cycle.
// rst_n is synchronous and clears the sequencer and the strobe.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module wide_signed_integer_alu
  import wsialu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_NEGA,
    ST_NEGB,
    ST_DIV,
    ST_FIX
  } state_t;

  state_t               state_r;
  logic [MODE_W-1:0]    mode_r;
  logic [WORD_W-1:0]    a_r;
  logic [WORD_W-1:0]    b_r;
  logic [WORD_W-1:0]    acc_r;
  logic [WORD_W-1:0]    rem_r;
  logic [SHAMT_W-1:0]   sh_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 nx_r;
  logic                 ny_r;
  logic                 lt_r;
  logic                 eq_r;
  logic                 gt_r;
  logic                 out_valid_r;
  out_t                 out_r;

  logic [WORD_W-1:0]    in_a;
  logic [WORD_W-1:0]    in_b;
  logic                 in_lt;
  logic                 in_eq;
  logic [WORD_W-1:0]    add_x;
  logic [WORD_W-1:0]    add_y;
  logic                 add_ci;
  logic [WORD_W:0]      sum;
  logic [WORD_W-1:0]    rem_sh;
  logic [WORD_W-1:0]    exec_res;
  logic                 cnt_last;

  assign in_a   = {in_data.a_high, in_data.a_low};
  assign in_b   = {in_data.b_high, in_data.b_low};
  assign in_eq  = (in_a == in_b);
  assign in_lt  = (in_a[WORD_W-1] != in_b[WORD_W-1]) ? in_a[WORD_W-1] : (in_a < in_b);

  assign rem_sh   = {rem_r[WORD_W-2:0], a_r[WORD_W-1]};
  assign cnt_last = (cnt_r == {CNT_W{1'b1}});

  // shared adder: operand selection per sequencer state
  always_comb begin
    add_x  = acc_r;
    add_y  = a_r;
    add_ci = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        add_x  = a_r;
        add_y  = (mode_r == MODE_SUB) ? ~b_r : b_r;
        add_ci = (mode_r == MODE_SUB);
      end
      ST_NEGA, ST_FIX: begin
        add_x  = '0;
        add_y  = ~a_r;
        add_ci = 1'b1;
      end
      ST_NEGB: begin
        add_x  = '0;
        add_y  = ~b_r;
        add_ci = 1'b1;
      end
      ST_DIV: begin
        add_x  = rem_sh;
        add_y  = ~b_r;
        add_ci = 1'b1;
      end
      ST_IDLE, ST_MUL: begin
        add_x  = acc_r;
        add_y  = a_r;
        add_ci = 1'b0;
      end
      default: begin
        add_x  = acc_r;
        add_y  = a_r;
        add_ci = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {{WORD_W{1'b0}}, add_ci};

  // operations that complete in ST_EXEC
  always_comb begin
    unique case (mode_r)
      MODE_ADD, MODE_SUB: exec_res = sum[WORD_W-1:0];
      MODE_AND:           exec_res = a_r & b_r;
      MODE_OR:            exec_res = a_r | b_r;
      MODE_XOR:           exec_res = a_r ^ b_r;
      MODE_NOT:           exec_res = ~a_r;
      MODE_SHL:           exec_res = a_r << sh_r;
      MODE_SHR:           exec_res = a_r >> sh_r;
      MODE_ROL:           exec_res = {a_r[WORD_W-2:0], a_r[WORD_W-1]};
      MODE_ROR:           exec_res = {a_r[0], a_r[WORD_W-1:1]};
      default:            exec_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            mode_r <= in_data.mode;
            a_r    <= in_a;
            b_r    <= in_b;
            sh_r   <= in_data.shift_amount;
            acc_r  <= '0;
            rem_r  <= '0;
            cnt_r  <= '0;
            nx_r   <= in_a[WORD_W-1];
            ny_r   <= in_b[WORD_W-1];
            lt_r   <= in_lt;
            eq_r   <= in_eq;
            gt_r   <= !in_eq && !in_lt;
            if (in_data.mode == MODE_MUL) begin
              state_r <= ST_MUL;
            end else if (in_data.mode == MODE_DIV && in_b != '0) begin
              state_r <= ST_NEGA;
            end else begin
              state_r <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          out_r       <= '{exec_res[HALF_W-1:0], exec_res[WORD_W-1:HALF_W], lt_r, eq_r, gt_r};
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        ST_MUL: begin
          // add the shifted multiplicand when the current multiplier bit is set
          if (b_r[0]) begin
            acc_r <= sum[WORD_W-1:0];
          end
          a_r   <= {a_r[WORD_W-2:0], 1'b0};
          b_r   <= {1'b0, b_r[WORD_W-1:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_last) begin
            out_r <= b_r[0]
                     ? out_t'{sum[HALF_W-1:0], sum[WORD_W-1:HALF_W], lt_r, eq_r, gt_r}
                     : out_t'{acc_r[HALF_W-1:0], acc_r[WORD_W-1:HALF_W], lt_r, eq_r, gt_r};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_NEGA: begin
          if (nx_r) begin
            a_r <= sum[WORD_W-1:0];
          end
          state_r <= ST_NEGB;
        end
        ST_NEGB: begin
          if (ny_r) begin
            b_r <= sum[WORD_W-1:0];
          end
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // carry out means the shifted remainder reaches the divisor
          rem_r <= sum[WORD_W] ? sum[WORD_W-1:0] : rem_sh;
          a_r   <= {a_r[WORD_W-2:0], sum[WORD_W]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_last) begin
            state_r <= ST_FIX;
          end
        end
        ST_FIX: begin
          out_r <= (nx_r != ny_r)
                   ? out_t'{sum[HALF_W-1:0], sum[WORD_W-1:HALF_W], lt_r, eq_r, gt_r}
                   : out_t'{a_r[HALF_W-1:0], a_r[WORD_W-1:HALF_W], lt_r, eq_r, gt_r};
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/wsialu_chk.sv -----
// ----------------------------------------------------------------------------
// wsialu_chk
// Port-level checks for the 128-bit signed integer ALU.
// ----------------------------------------------------------------------------
module wsialu_chk
  import wsialu_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  // a taken word keeps the unit busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // busy drops only with the result strobe
  a_fall_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.is_less, out_data.is_equal, out_data.is_greater}))
    else $error("compare flags not one-hot");

  // an accepted add strobes its result after its ST_EXEC state
  a_add_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.mode == MODE_ADD) |=> ##1 out_valid)
    else $error("add result late");

endmodule

bind wide_signed_integer_alu wsialu_chk u_wsialu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ----- dv/wide_signed_integer_alu_checker.sv -----
// ----------------------------------------------------------------------------
// wide_signed_integer_alu_checker
// Watches the command and result channels of the 128-bit ALU, works out the
// result and compare flags of every accepted word, and checks each strobed
// result against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module wide_signed_integer_alu_checker
  import wsialu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_data,
  input  logic        out_valid,
  input  out_t        out_data,
  output int unsigned mismatches,
  output int unsigned results_due
);

  out_t pending_results[$];
  out_t want;

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  function automatic out_t compute_alu_result(input in_t w);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
    logic [WORD_W-1:0] quo;
    out_t              res;
    a = {w.a_high, w.a_low};
    b = {w.b_high, w.b_low};
    case (w.mode)
      MODE_ADD: r = a + b;
      MODE_SUB: r = a - b;
      MODE_MUL: r = a * b;
      MODE_DIV: begin
        // truncate toward zero on magnitudes; the most negative value keeps
        // its pattern when negated, which wraps min / -1 back to min
        if (b == '0) begin
          r = '0;
        end else begin
          mag_a = a[WORD_W-1] ? -a : a;
          mag_b = b[WORD_W-1] ? -b : b;
          quo   = mag_a / mag_b;
          r     = (a[WORD_W-1] ^ b[WORD_W-1]) ? -quo : quo;
        end
      end
      MODE_AND: r = a & b;
      MODE_OR:  r = a | b;
      MODE_XOR: r = a ^ b;
      MODE_NOT: r = ~a;
      MODE_SHL: r = a << w.shift_amount;
      MODE_SHR: r = a >> w.shift_amount;
      MODE_ROL: r = {a[WORD_W-2:0], a[WORD_W-1]};
      MODE_ROR: r = {a[0], a[WORD_W-1:1]};
      default:  r = '0;
    endcase
    res.result_low  = r[HALF_W-1:0];
    res.result_high = r[WORD_W-1:HALF_W];
    res.is_equal    = (a == b);
    res.is_less     = ($signed(a) < $signed(b));
    res.is_greater  = ($signed(a) > $signed(b));
    return res;
  endfunction

  task automatic check_field(input string name, input logic [HALF_W-1:0] exp_val,
                             input logic [HALF_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        pending_results.push_back(compute_alu_result(in_data));
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected: expected none, actual %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_low", want.result_low, out_data.result_low);
          check_field("result_high", want.result_high, out_data.result_high);
          check_field("is_less", 64'(want.is_less), 64'(out_data.is_less));
          check_field("is_equal", 64'(want.is_equal), 64'(out_data.is_equal));
          check_field("is_greater", 64'(want.is_greater), 64'(out_data.is_greater));
        end
      end
    end
    results_due <= pending_results.size();
  end

endmodule

// ----- dv/wide_signed_integer_alu_test.sv -----
// ----------------------------------------------------------------------------
// wide_signed_integer_alu_test
// Drives directed corner words and then random words into the 128-bit ALU
// through three sender idle profiles; a checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module wide_signed_integer_alu_test
  import wsialu_pkg::*;
;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 4'd13;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 4'd15;
  localparam logic [WORD_W-1:0] MOST_NEG   = {1'b1, 127'd0};
  localparam logic [WORD_W-1:0] MOST_POS   = ~MOST_NEG;
  localparam logic [WORD_W-1:0] ALL_ONES   = '1;
  localparam logic [WORD_W-1:0] CHECKER    = {4{32'hA5C3_0F96}};
  localparam int unsigned       STALL_LIMIT = 2000;
  localparam int unsigned       WORDS_PER_PHASE = 584;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  in_t         in_data = '0;
  logic        busy;
  logic        out_valid;
  out_t        out_data;
  int unsigned mismatches;
  int unsigned results_due;
  int unsigned send_idle_pct = 11;
  int unsigned idle_cycles = 0;

  wide_signed_integer_alu u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  wide_signed_integer_alu_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("wide_signed_integer_alu verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drive_word(input in_t word);
    int unsigned gap;
    gap = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 140 : 6);
    in_data <= word;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // drop start now and then so idle gaps fall between words
    if ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue_op(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] a,
                          input logic [WORD_W-1:0] b, input logic [SHAMT_W-1:0] shamt);
    in_t w;
    w.mode         = mode;
    w.a_low        = a[HALF_W-1:0];
    w.a_high       = a[WORD_W-1:HALF_W];
    w.b_low        = b[HALF_W-1:0];
    w.b_high       = b[WORD_W-1:HALF_W];
    w.shift_amount = shamt;
    drive_word(w);
  endtask

  function automatic logic [WORD_W-1:0] pick_operand();
    logic [WORD_W-1:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = 128'd1;
          2:       v = ALL_ONES;
          3:       v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      1: begin
        v = WORD_W'($urandom_range(0, 200));
        v = v - 128'd100;
      end
      2: v = {64'd0, v[HALF_W-1:0]};
      3: v = {{64{1'b1}}, v[HALF_W-1:0]};
      4: v = v >> $urandom_range(1, 127);
      default: ;
    endcase
    return v;
  endfunction

  task automatic issue_random();
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = pick_operand();
    // equal operands now and then so the equal flag gets exercised
    b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
    issue_op(MODE_W'($urandom_range(MODE_ADD, MODE_SPARE_LAST)), a, b,
             SHAMT_W'($urandom_range(0, 127)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    issue_op(MODE_ADD, MOST_POS, 128'd1, 7'd0);
    issue_op(MODE_ADD, ALL_ONES, ALL_ONES, 7'd127);
    issue_op(MODE_SUB, MOST_NEG, 128'd1, 7'd0);
    issue_op(MODE_SUB, '0, MOST_NEG, 7'd0);
    issue_op(MODE_MUL, MOST_NEG, ALL_ONES, 7'd0);
    issue_op(MODE_MUL, MOST_POS, MOST_POS, 7'd0);
    issue_op(MODE_MUL, 128'd0 - 128'd3, 128'd5, 7'd0);
    issue_op(MODE_DIV, 128'd100, '0, 7'd0);
    issue_op(MODE_DIV, MOST_NEG, ALL_ONES, 7'd0);
    issue_op(MODE_DIV, 128'd0 - 128'd7, 128'd2, 7'd0);
    issue_op(MODE_DIV, 128'd7, 128'd0 - 128'd2, 7'd0);
    issue_op(MODE_AND, ALL_ONES, CHECKER, 7'd0);
    issue_op(MODE_OR, CHECKER, ~CHECKER, 7'd0);
    issue_op(MODE_XOR, ALL_ONES, CHECKER, 7'd0);
    issue_op(MODE_NOT, '0, ALL_ONES, 7'd0);
    issue_op(MODE_SHL, CHECKER, '0, 7'd0);
    issue_op(MODE_SHL, ALL_ONES, '0, 7'd127);
    issue_op(MODE_SHR, ALL_ONES, '0, 7'd127);
    issue_op(MODE_SHR, CHECKER, '0, 7'd64);
    issue_op(MODE_ROL, MOST_NEG | 128'd1, '0, 7'd100);
    issue_op(MODE_ROR, 128'd1, '0, 7'd55);
    issue_op(MODE_CMP, CHECKER, CHECKER, 7'd0);
    issue_op(MODE_CMP, MOST_NEG, MOST_POS, 7'd0);
    issue_op(MODE_SPARE_LAST, MOST_POS, MOST_NEG, 7'd127);
    issue_op(MODE_SPARE_FIRST, ALL_ONES, '0, 7'd3);

    repeat (WORDS_PER_PHASE) issue_random();
    send_idle_pct = 52;
    repeat (WORDS_PER_PHASE) issue_random();
    send_idle_pct = 0;
    repeat (WORDS_PER_PHASE) issue_random();
    start <= 1'b0;

    // let the checker count the last accepted word before draining
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && results_due == 0) begin
      $display("wide_signed_integer_alu verification clean");
    end else begin
      $display("wide_signed_integer_alu verification failed");
    end
    $finish;
  end

endmodule
